// ===== hw/rtl/ifhc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the IPv4 flow header classifier.
// Types, byte offsets, verdict codes and hash constants; no dependencies.
package ifhc_pkg;

	localparam int CNT_W = 16;
	localparam logic [CNT_W-1:0] FRAME_COUNT_LIMIT = 16'hFFFF;

	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [15:0] FRAG_ANY_BITS = 16'h3FFF;
	localparam logic [15:0] FRAG_OFFSET_BITS = 16'h1FFF;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [3:0] IP_VERSION_4 = 4'd4;
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam logic [CNT_W-1:0] ETH_HDR_LEN = 16'd14;
	localparam logic [CNT_W-1:0] IP_MIN_HDR = 16'd20;
	localparam logic [CNT_W-1:0] PORT_BYTES = 16'd4;

	localparam logic [CNT_W-1:0] POS_ETH_HI = 16'd12;
	localparam logic [CNT_W-1:0] POS_ETH_LO = 16'd13;
	localparam logic [CNT_W-1:0] POS_VIHL = 16'd14;
	localparam logic [CNT_W-1:0] POS_TLEN_HI = 16'd16;
	localparam logic [CNT_W-1:0] POS_TLEN_LO = 16'd17;
	localparam logic [CNT_W-1:0] POS_ID_HI = 16'd18;
	localparam logic [CNT_W-1:0] POS_ID_LO = 16'd19;
	localparam logic [CNT_W-1:0] POS_FRAG_HI = 16'd20;
	localparam logic [CNT_W-1:0] POS_FRAG_LO = 16'd21;
	localparam logic [CNT_W-1:0] POS_PROTO = 16'd23;
	localparam logic [CNT_W-1:0] POS_SADDR_FIRST = 16'd26;
	localparam logic [CNT_W-1:0] POS_SADDR_LAST = 16'd29;
	localparam logic [CNT_W-1:0] POS_DADDR_FIRST = 16'd30;
	localparam logic [CNT_W-1:0] POS_DADDR_LAST = 16'd33;

	typedef enum logic [1:0] {
		VERDICT_PASS       = 2'd0,
		VERDICT_FLOW       = 2'd1,
		VERDICT_FIRST_FRAG = 2'd2,
		VERDICT_LATER_FRAG = 2'd3
	} verdict_t;

	typedef enum logic [1:0] {
		MIX_SRC   = 2'd0,
		MIX_DST   = 2'd1,
		MIX_PORTS = 2'd2,
		MIX_PROTO = 2'd3
	} mix_sel_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [31:0] hash_value;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_l4_port;
		logic [15:0] dst_l4_port;
		logic [7:0]  protocol;
		logic [15:0] identification;
	} out_item_t;

	typedef struct packed {
		logic     take;
		logic     snap;
		logic     mix_en;
		mix_sel_t mix_sel;
		logic     load_out;
	} ifhc_cmd_t;

	typedef struct packed {
		logic out_full;
	} ifhc_sts_t;

endpackage

// ===== hw/rtl/ipv4_flow_header_classifier_core.sv =====
`timescale 1ns / 1ps
// Top level of the IPv4 flow header classifier: frame bytes in, one classification per frame.
// Depends on ifhc_pkg, ifhc_ctrl and ifhc_datapath.
// The result is registered once the hash has mixed source, destination, ports and protocol in turn.
// Throughput: one byte per cycle while in_stall is low; a last byte waits while the previous result
// is held, and input then stalls while the four hash words pass through the 32x32 multiplier.
// Reset: arst_n clears frame state, the result valid flag and fragment_enable.
module ipv4_flow_header_classifier_core import ifhc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	ifhc_cmd_t cmd;
	ifhc_sts_t sts;

	ifhc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last     (in_data.last_byte),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ifhc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ===== hw/rtl/ifhc_ctrl.sv =====
`timescale 1ns / 1ps
// Controller for the IPv4 flow header classifier: input handshake and hash sequencing.
// Depends on ifhc_pkg.
module ifhc_ctrl import ifhc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      last,
	output logic      in_stall,
	input  ifhc_sts_t sts,
	output ifhc_cmd_t cmd
);

	typedef enum logic [4:0] {
		ST_IDLE      = 5'b00001,
		ST_MIX_SRC   = 5'b00010,
		ST_MIX_DST   = 5'b00100,
		ST_MIX_PORTS = 5'b01000,
		ST_MIX_PROTO = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   take;

	// a closing byte waits until the result register is free
	assign in_stall = (state_q != ST_IDLE) || (sts.out_full && last);
	assign take     = in_valid && !in_stall;

	always_comb begin
		state_nxt    = state_q;
		cmd.take     = take;
		cmd.snap     = 1'b0;
		cmd.mix_en   = 1'b0;
		cmd.mix_sel  = MIX_SRC;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (take && last) begin
					cmd.snap  = 1'b1;
					state_nxt = ST_MIX_SRC;
				end
			end
			ST_MIX_SRC: begin
				cmd.mix_en  = 1'b1;
				cmd.mix_sel = MIX_SRC;
				state_nxt   = ST_MIX_DST;
			end
			ST_MIX_DST: begin
				cmd.mix_en  = 1'b1;
				cmd.mix_sel = MIX_DST;
				state_nxt   = ST_MIX_PORTS;
			end
			ST_MIX_PORTS: begin
				cmd.mix_en  = 1'b1;
				cmd.mix_sel = MIX_PORTS;
				state_nxt   = ST_MIX_PROTO;
			end
			ST_MIX_PROTO: begin
				cmd.mix_en   = 1'b1;
				cmd.mix_sel  = MIX_PROTO;
				cmd.load_out = 1'b1;
				state_nxt    = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== hw/rtl/ifhc_datapath.sv =====
`timescale 1ns / 1ps
// Datapath for the IPv4 flow header classifier: header capture, checks, hash, result register.
// Depends on ifhc_pkg.
module ifhc_datapath import ifhc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	input  in_item_t  in_data,
	input  ifhc_cmd_t cmd,
	output ifhc_sts_t sts,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic             frag_en_q;

	logic [CNT_W-1:0] cnt_q, cnt_nxt;
	logic [15:0]      eth_q, eth_nxt;
	logic [7:0]       vihl_q, vihl_nxt;
	logic [15:0]      tlen_q, tlen_nxt;
	logic [15:0]      ident_q, ident_nxt;
	logic [15:0]      frag_q, frag_nxt;
	logic [7:0]       proto_q, proto_nxt;
	logic [31:0]      saddr_q, saddr_nxt;
	logic [31:0]      daddr_q, daddr_nxt;
	logic [15:0]      sport_q, sport_nxt;
	logic [15:0]      dport_q, dport_nxt;

	logic [CNT_W-1:0] sn_cnt_q;
	logic [15:0]      sn_eth_q;
	logic [7:0]       sn_vihl_q;
	logic [15:0]      sn_tlen_q;
	logic [15:0]      sn_ident_q;
	logic [15:0]      sn_frag_q;
	logic [7:0]       sn_proto_q;
	logic [31:0]      sn_saddr_q;
	logic [31:0]      sn_daddr_q;
	logic [15:0]      sn_sport_q;
	logic [15:0]      sn_dport_q;

	logic [31:0]      hash_q;
	logic [31:0]      mix_v;
	logic [31:0]      mult_a;
	logic [31:0]      prod;

	logic             out_valid_q;
	out_item_t        out_q;
	out_item_t        out_nxt;

	logic [CNT_W-1:0] poff;
	logic [CNT_W-1:0] pos;
	logic [CNT_W-1:0] hlen;
	logic [CNT_W:0]   tlen_plus_eth;
	logic [CNT_W:0]   need_frame;
	logic             hdr_ok;
	logic             is_frag;
	logic             is_later;
	logic             l4_ok;
	verdict_t         verdict;

	// header capture
	assign pos  = cnt_q;
	assign poff = ETH_HDR_LEN + {{(CNT_W-6){1'b0}}, vihl_q[3:0], 2'b00};

	always_comb begin
		cnt_nxt   = cnt_q;
		eth_nxt   = eth_q;
		vihl_nxt  = vihl_q;
		tlen_nxt  = tlen_q;
		ident_nxt = ident_q;
		frag_nxt  = frag_q;
		proto_nxt = proto_q;
		saddr_nxt = saddr_q;
		daddr_nxt = daddr_q;
		sport_nxt = sport_q;
		dport_nxt = dport_q;
		if (cmd.take && (pos < FRAME_COUNT_LIMIT)) begin
			if (pos == POS_ETH_HI || pos == POS_ETH_LO) begin
				eth_nxt = {eth_q[7:0], in_data.data_byte};
			end else if (pos == POS_VIHL) begin
				vihl_nxt = in_data.data_byte;
			end else if (pos == POS_TLEN_HI || pos == POS_TLEN_LO) begin
				tlen_nxt = {tlen_q[7:0], in_data.data_byte};
			end else if (pos == POS_ID_HI || pos == POS_ID_LO) begin
				ident_nxt = {ident_q[7:0], in_data.data_byte};
			end else if (pos == POS_FRAG_HI || pos == POS_FRAG_LO) begin
				frag_nxt = {frag_q[7:0], in_data.data_byte};
			end else if (pos == POS_PROTO) begin
				proto_nxt = in_data.data_byte;
			end else if (pos >= POS_SADDR_FIRST && pos <= POS_SADDR_LAST) begin
				saddr_nxt = {saddr_q[23:0], in_data.data_byte};
			end else if (pos >= POS_DADDR_FIRST && pos <= POS_DADDR_LAST) begin
				daddr_nxt = {daddr_q[23:0], in_data.data_byte};
			end
			// port offset follows the header length held before this byte
			if (pos == poff || pos == poff + 16'd1) begin
				sport_nxt = {sport_q[7:0], in_data.data_byte};
			end else if (pos == poff + 16'd2 || pos == poff + 16'd3) begin
				dport_nxt = {dport_q[7:0], in_data.data_byte};
			end
			cnt_nxt = pos + 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frag_en_q <= 1'b0;
			cnt_q     <= '0;
			eth_q     <= '0;
			vihl_q    <= '0;
			tlen_q    <= '0;
			ident_q   <= '0;
			frag_q    <= '0;
			proto_q   <= '0;
			saddr_q   <= '0;
			daddr_q   <= '0;
			sport_q   <= '0;
			dport_q   <= '0;
		end else begin
			if (cfg_we) begin
				frag_en_q <= cfg_wdata;
			end
			if (cmd.snap) begin
				cnt_q   <= '0;
				eth_q   <= '0;
				vihl_q  <= '0;
				tlen_q  <= '0;
				ident_q <= '0;
				frag_q  <= '0;
				proto_q <= '0;
				saddr_q <= '0;
				daddr_q <= '0;
				sport_q <= '0;
				dport_q <= '0;
			end else begin
				cnt_q   <= cnt_nxt;
				eth_q   <= eth_nxt;
				vihl_q  <= vihl_nxt;
				tlen_q  <= tlen_nxt;
				ident_q <= ident_nxt;
				frag_q  <= frag_nxt;
				proto_q <= proto_nxt;
				saddr_q <= saddr_nxt;
				daddr_q <= daddr_nxt;
				sport_q <= sport_nxt;
				dport_q <= dport_nxt;
			end
		end
	end

	// frame snapshot, taken on the closing byte
	always_ff @(posedge clk) begin
		if (cmd.snap) begin
			sn_cnt_q   <= cnt_nxt;
			sn_eth_q   <= eth_nxt;
			sn_vihl_q  <= vihl_nxt;
			sn_tlen_q  <= tlen_nxt;
			sn_ident_q <= ident_nxt;
			sn_frag_q  <= frag_nxt;
			sn_proto_q <= proto_nxt;
			sn_saddr_q <= saddr_nxt;
			sn_daddr_q <= daddr_nxt;
			sn_sport_q <= sport_nxt;
			sn_dport_q <= dport_nxt;
		end
	end

	// header checks
	assign hlen          = {{(CNT_W-6){1'b0}}, sn_vihl_q[3:0], 2'b00};
	assign tlen_plus_eth = {1'b0, sn_tlen_q} + {1'b0, ETH_HDR_LEN};
	assign need_frame    = {1'b0, ETH_HDR_LEN} + {1'b0, hlen} + {1'b0, PORT_BYTES};
	assign is_frag       = (sn_frag_q & FRAG_ANY_BITS) != 16'd0;
	assign is_later      = (sn_frag_q & FRAG_OFFSET_BITS) != 16'd0;

	assign hdr_ok = (sn_cnt_q >= ETH_HDR_LEN + IP_MIN_HDR) && (sn_eth_q == ETHERTYPE_IPV4)
		&& (sn_vihl_q[7:4] == IP_VERSION_4) && (hlen >= IP_MIN_HDR)
		&& (sn_tlen_q >= hlen) && (tlen_plus_eth <= {1'b0, sn_cnt_q});

	assign l4_ok = (sn_proto_q == PROTO_TCP || sn_proto_q == PROTO_UDP)
		&& (hlen + PORT_BYTES <= sn_tlen_q) && (need_frame <= {1'b0, sn_cnt_q});

	always_comb begin
		verdict = VERDICT_PASS;
		if (hdr_ok) begin
			if (is_frag && is_later) begin
				verdict = frag_en_q ? VERDICT_LATER_FRAG : VERDICT_PASS;
			end else if (l4_ok) begin
				if (!is_frag) begin
					verdict = VERDICT_FLOW;
				end else begin
					verdict = frag_en_q ? VERDICT_FIRST_FRAG : VERDICT_PASS;
				end
			end
		end
	end

	// hash: one multiply per word; addresses and each port byte-swapped
	always_comb begin
		case (cmd.mix_sel)
			MIX_SRC:   mix_v = {sn_saddr_q[7:0], sn_saddr_q[15:8], sn_saddr_q[23:16],
				sn_saddr_q[31:24]};
			MIX_DST:   mix_v = {sn_daddr_q[7:0], sn_daddr_q[15:8], sn_daddr_q[23:16],
				sn_daddr_q[31:24]};
			MIX_PORTS: mix_v = {sn_sport_q[7:0], sn_sport_q[15:8], sn_dport_q[7:0],
				sn_dport_q[15:8]};
			MIX_PROTO: mix_v = {24'd0, sn_proto_q};
			default:   mix_v = '0;
		endcase
	end

	assign mult_a = hash_q ^ mix_v;
	assign prod   = mult_a * FNV_PRIME;

	always_ff @(posedge clk) begin
		if (cmd.snap) begin
			hash_q <= FNV_BASIS;
		end else if (cmd.mix_en) begin
			hash_q <= prod;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		out_nxt         = '0;
		out_nxt.verdict = verdict;
		if (verdict != VERDICT_PASS) begin
			out_nxt.src_ip         = sn_saddr_q;
			out_nxt.dst_ip         = sn_daddr_q;
			out_nxt.protocol       = sn_proto_q;
			out_nxt.identification = sn_ident_q;
			if (verdict != VERDICT_LATER_FRAG) begin
				out_nxt.hash_value  = prod;
				out_nxt.src_l4_port = sn_sport_q;
				out_nxt.dst_l4_port = sn_dport_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q <= out_nxt;
		end
	end

	assign sts.out_full = out_valid_q;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

endmodule
